@@ hdl/fha_pkg.sv @@
// fha_pkg: shared constants, codes and types of the first-fit heap allocator.
// No dependencies; fha_if, fha_engine and the core refer to it by scoped names.
package fha_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 32;
   localparam int HEAP_BYTES   = 65536;
   localparam int ADDR_SPAN    = 65536;
   localparam int LIMIT_CAP    = (HEAP_BYTES < ADDR_SPAN) ? HEAP_BYTES : ADDR_SPAN;

   localparam int ADDR_W  = 16;
   localparam int BYTE_W  = 17;
   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
   localparam logic [1:0] ST_BAD_BLOCK = 2'd2;
   localparam logic [1:0] ST_NO_MEM    = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] start;
      logic [BYTE_W-1:0] size;
      logic              free;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              go;
      logic              ack;
      logic              op;
      logic [ADDR_W-1:0] req_size;
      logic [ADDR_W-1:0] block_addr;
      logic [BYTE_W-1:0] limit;
   } cmd_type;

   typedef struct packed {
      logic              done;
      logic              idle;
      logic [ADDR_W-1:0] result_addr;
      logic [1:0]        status;
   } res_type;

endpackage

@@ hdl/fha_if.sv @@
// fha_if: valid/ready channel interfaces for requests and responses.
// Depends on fha_pkg for field widths.
interface fha_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [fha_pkg::ADDR_W-1:0] req_size;
   logic [fha_pkg::ADDR_W-1:0] block_addr;
   modport source (output valid, op, req_size, block_addr, input ready);
   modport sink (input valid, op, req_size, block_addr, output ready);
endinterface

interface fha_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fha_pkg::ADDR_W-1:0] result_addr;
   logic [1:0]                status;
   modport source (output valid, result_addr, status, input ready);
   modport sink (input valid, result_addr, status, output ready);
endinterface

@@ hdl/fha_ram.sv @@
// fha_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module fha_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 35,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/fha_engine.sv @@
// fha_engine: scan sequencer over the block table; first-fit search, append,
// and free with in-place compaction (merge + trim). Uses fha_pkg, fha_ram.
module fha_engine (
   input  logic             clock,
   input  logic             reset,
   input  fha_pkg::cmd_type cmd,
   output fha_pkg::res_type res
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       op_ff, op_in;
   logic [fha_pkg::ADDR_W-1:0] size_ff, size_in, baddr_ff, baddr_in;
   logic [fha_pkg::BYTE_W-1:0] limit_ff, limit_in;
   logic [fha_pkg::CNT_W-1:0]  rd_idx_ff, rd_idx_in, wr_idx_ff, wr_idx_in;
   logic [fha_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [fha_pkg::IDX_W-1:0]  cur_idx_ff, cur_idx_in;
   logic       pend_ff, pend_in, held_vld_ff, held_vld_in, found_ff, found_in;
   fha_pkg::entry_type held_ff, held_in;
   logic [fha_pkg::BYTE_W-1:0] top_ff, top_in;
   logic [fha_pkg::ADDR_W-1:0] raddr_ff, raddr_in;
   logic [1:0] status_ff, status_in;

   logic rd_en, wr_en;
   logic [fha_pkg::IDX_W-1:0] wr_addr;
   fha_pkg::entry_type wr_entry, rd_entry, upd;
   logic [fha_pkg::ENTRY_W-1:0] rd_word;
   logic [fha_pkg::BYTE_W:0] need;
   logic [fha_pkg::BYTE_W-1:0] eff_limit;
   logic hit, mark;

   fha_ram #(.DEPTH(fha_pkg::MAX_BLOCKS), .WIDTH(fha_pkg::ENTRY_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[fha_pkg::IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry  = fha_pkg::entry_type'(rd_word);
   assign eff_limit = (limit_ff > fha_pkg::BYTE_W'(fha_pkg::LIMIT_CAP)) ?
                      fha_pkg::BYTE_W'(fha_pkg::LIMIT_CAP) : limit_ff;
   assign need = {1'b0, top_ff} + (fha_pkg::BYTE_W+1)'(fha_pkg::HEADER_BYTES)
                 + {2'b00, size_ff};
   assign hit  = rd_entry.free && (rd_entry.size >= {1'b0, size_ff});
   assign mark = !rd_entry.free && ((rd_entry.start +
                 fha_pkg::BYTE_W'(fha_pkg::HEADER_BYTES)) == {1'b0, baddr_ff});

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      size_in     = size_ff;
      baddr_in    = baddr_ff;
      limit_in    = limit_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      count_in    = count_ff;
      cur_idx_in  = cur_idx_ff;
      pend_in     = 1'b0;
      held_vld_in = held_vld_ff;
      found_in    = found_ff;
      held_in     = held_ff;
      top_in      = top_ff;
      raddr_in    = raddr_ff;
      status_in   = status_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cur_idx_ff;
      wr_entry    = rd_entry;
      upd         = rd_entry;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.go) begin
               op_in       = cmd.op;
               size_in     = cmd.req_size;
               baddr_in    = cmd.block_addr;
               limit_in    = cmd.limit;
               rd_idx_in   = '0;
               wr_idx_in   = '0;
               held_vld_in = 1'b0;
               found_in    = 1'b0;
               raddr_in    = '0;
               if (cmd.op == fha_pkg::OP_ALLOC && cmd.req_size == '0) begin
                  status_in = fha_pkg::ST_BAD_SIZE;
                  state_in  = S_DONE;
               end else begin
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue the next read while the previous entry is evaluated
            if (rd_idx_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               cur_idx_in = rd_idx_ff[fha_pkg::IDX_W-1:0];
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               if (op_ff == fha_pkg::OP_ALLOC) begin
                  if (hit) begin
                     wr_en         = 1'b1;
                     wr_entry.free = 1'b0;
                     raddr_in  = fha_pkg::ADDR_W'(rd_entry.start +
                                 fha_pkg::BYTE_W'(fha_pkg::HEADER_BYTES));
                     status_in = fha_pkg::ST_OK;
                     state_in  = S_DONE;
                  end
               end else begin
                  upd.free = rd_entry.free | mark;
                  found_in = found_ff | mark;
                  if (!held_vld_ff) begin
                     held_in     = upd;
                     held_vld_in = 1'b1;
                  end else if (held_ff.free && upd.free) begin
                     held_in.size = held_ff.size +
                        fha_pkg::BYTE_W'(fha_pkg::HEADER_BYTES) + upd.size;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = wr_idx_ff[fha_pkg::IDX_W-1:0];
                     wr_entry  = held_ff;
                     wr_idx_in = wr_idx_ff + 1'b1;
                     held_in   = upd;
                  end
               end
            end else if (rd_idx_ff >= count_ff) begin
               state_in = S_DONE;
               if (op_ff == fha_pkg::OP_ALLOC) begin
                  if (count_ff == fha_pkg::CNT_W'(fha_pkg::MAX_BLOCKS) ||
                      need > {1'b0, eff_limit}) begin
                     status_in = fha_pkg::ST_NO_MEM;
                  end else begin
                     wr_en          = 1'b1;
                     wr_addr        = count_ff[fha_pkg::IDX_W-1:0];
                     wr_entry.start = top_ff;
                     wr_entry.size  = {1'b0, size_ff};
                     wr_entry.free  = 1'b0;
                     count_in  = count_ff + 1'b1;
                     top_in    = need[fha_pkg::BYTE_W-1:0];
                     raddr_in  = fha_pkg::ADDR_W'(top_ff +
                                 fha_pkg::BYTE_W'(fha_pkg::HEADER_BYTES));
                     status_in = fha_pkg::ST_OK;
                  end
               end else begin
                  status_in = found_ff ? fha_pkg::ST_OK : fha_pkg::ST_BAD_BLOCK;
                  if (held_vld_ff) begin
                     if (held_ff.free) begin
                        // trailing free block gives its space back
                        top_in   = held_ff.start;
                        count_in = wr_idx_ff;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = wr_idx_ff[fha_pkg::IDX_W-1:0];
                        wr_entry = held_ff;
                        count_in = wr_idx_ff + 1'b1;
                     end
                  end
               end
            end
         end
         S_DONE: begin
            if (cmd.ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         pend_ff  <= pend_in;
      end
      op_ff       <= op_in;
      size_ff     <= size_in;
      baddr_ff    <= baddr_in;
      limit_ff    <= limit_in;
      rd_idx_ff   <= rd_idx_in;
      wr_idx_ff   <= wr_idx_in;
      cur_idx_ff  <= cur_idx_in;
      held_vld_ff <= held_vld_in;
      found_ff    <= found_in;
      held_ff     <= held_in;
      raddr_ff    <= raddr_in;
      status_ff   <= status_in;
   end

   assign res.done        = (state_ff == S_DONE);
   assign res.idle        = (state_ff == S_IDLE);
   assign res.result_addr = raddr_ff;
   assign res.status      = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fha_pkg::CNT_W'(fha_pkg::MAX_BLOCKS))
      else $error("block count above table depth");
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= fha_pkg::BYTE_W'(fha_pkg::LIMIT_CAP))
      else $error("heap end above address span");
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("read in flight while idle");
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff != fha_pkg::ST_OK) |-> raddr_ff == '0)
      else $error("failed request carries an address");
endmodule

@@ hdl/first_fit_heap_allocator_core.sv @@
// first_fit_heap_allocator_core: top level of the first-fit heap allocator.
// Uses fha_pkg, fha_if (fha_req_if, fha_rsp_if) and fha_engine.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------
//  req_ch   | in  | valid/ready       | op, req_size, block_addr
//  rsp_ch   | out | valid/ready       | result_addr, status
//  csr_*    | in  | csr_wr_en         | csr_wr_data = heap_limit
//
// One item at a time; the engine scans N table entries, N the number of
// entries (at most 64), with one table read per cycle from the RAM.
// Allocate stops at the first fitting block; free and misses scan all of N.
// Reset clears entry count, heap end and the response slot; limit -> 65536.
// A finished response waits in the output register; the next item is
// accepted meanwhile, and the engine holds its result if that slot is full.
module first_fit_heap_allocator_core (
   input  logic                       clock,
   input  logic                       reset,
   fha_req_if.sink                    req_ch,
   fha_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [fha_pkg::BYTE_W-1:0] csr_wr_data
);
   logic [fha_pkg::BYTE_W-1:0] limit_ff;
   logic                       rsp_valid_ff;
   logic [fha_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic [1:0]                 rsp_status_ff;
   fha_pkg::cmd_type           cmd;
   fha_pkg::res_type           res;
   logic                       load;

   // output slot takes the result when empty or being drained
   assign load = res.done && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready   = res.idle;
   assign cmd.go         = req_ch.valid && res.idle;
   assign cmd.ack        = load;
   assign cmd.op         = req_ch.op;
   assign cmd.req_size   = req_ch.req_size;
   assign cmd.block_addr = req_ch.block_addr;
   assign cmd.limit      = limit_ff;

   fha_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= fha_pkg::BYTE_W'(65536);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         rsp_addr_ff   <= res.result_addr;
         rsp_status_ff <= res.status;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;
   assign rsp_ch.status      = rsp_status_ff;

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !res.idle)
      else $error("accepted item did not start the engine");
   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("response slot not filled");
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !load)
      else $error("response overwritten");
endmodule
